### design/rle_coverage_encoder_defines.svh
// Assertion macros shared by the run-length encoder checker.
`ifndef RLE_COVERAGE_ENCODER_DEFINES_SVH
`define RLE_COVERAGE_ENCODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RLE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rle_coverage_encoder: check failed");

// Next-cycle implication, ignored while reset is high.
`define RLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rle_coverage_encoder: check failed");

// Next-cycle implication that is also checked across reset.
`define RLE_ASSERT_RESET(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rle_coverage_encoder: reset check failed");

`endif

### design/rlecov_pkg.sv
// Shared constants and types of the run-length coverage encoder.
package rlecov_pkg;

   localparam int MAX_RUN_DEFAULT     = 127;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam logic [7:0] FULL_COVER  = 8'd128;
   localparam logic [7:0] MARKER_BASE = 8'd128;

   // Largest number of code bytes a single item can produce.
   localparam int ITEM_BYTES_MAX = 3;
   localparam int QUEUE_DEPTH    = 8;

   typedef struct packed {
      logic [15:0] line_length;
      logic [15:0] line_start;
      logic        final_byte;
      logic [7:0]  code_byte;
   } rlecov_entry_type;

endpackage

### design/rle_coverage_encoder.sv
// Top level of the run-length encoder for coverage scanlines.
//
// The block takes one pixel coverage value per item and turns each scanline into a
// run-length code stream. A lone value leaves as a literal byte (values above 128 are
// clamped to 128); a run of equal values leaves as a marker byte, 128 plus the count,
// followed by the value. Runs are cut into chunks of MAX_RUN, each sent as soon as it
// fills, and a remainder of one after a full chunk still uses a marker. The item with
// req_tlast set flushes the open run; the last code byte of the line carries rsp_tlast
// together with the start position sampled on the line's first item and the pixel count,
// which saturates at the smaller of 2^LENGTH_BITS - 1 and 65535. An accepted item waits in
// an input register until the queue has room for a worst-case item, the run logic then
// writes its zero to three code bytes into an eight-entry result queue, and the queue
// delivers one byte per cycle while the receiver does not stall. A new item is taken in
// every cycle as long as the queue has room for the three bytes that one item can make;
// the sustained rate is therefore one item per cycle while the output averages no more
// than one byte per item and the receiver does not stall, and is otherwise set by the
// single-byte output port.
module rle_coverage_encoder #(
   parameter int MAX_RUN     = rlecov_pkg::MAX_RUN_DEFAULT,
   parameter int LENGTH_BITS = rlecov_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] coverage, [23:8] start_x
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] code_byte, [23:8] line_start, [39:24] line_length
   output logic        rsp_tlast    // final_byte
);
   import rlecov_pkg::*;

   localparam int RunW = $clog2(MAX_RUN + 1);
   localparam int CntW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam logic [CntW-1:0] LengthCeiling = {CntW{1'b1}};
   localparam logic [PtrW:0]   AdvanceLimit  = (PtrW + 1)'(QUEUE_DEPTH - ITEM_BYTES_MAX);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_cov_ff;
   logic [15:0] in_sx_ff;
   logic        in_eol_ff;

   // Run state.
   logic            pending_ff, pending_in;
   logic [7:0]      held_ff, held_in;
   logic [RunW-1:0] run_count_ff, run_count_in;
   logic            chunk_ff, chunk_in;
   logic [CntW-1:0] pixel_total_ff, pixel_total_in;
   logic [15:0]     line_origin_ff, line_origin_in;

   // Result queue.
   rlecov_entry_type queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    count_ff, count_in;

   logic             accept, advance, pop;
   logic [7:0]       cov_clamped;
   rlecov_entry_type slot [ITEM_BYTES_MAX];
   logic [1:0]       slot_count;
   logic [1:0]       push_count;
   logic [15:0]      origin;
   logic [CntW-1:0]  total_step;
   rlecov_entry_type head;

   // The input register moves on whenever the queue can take a worst-case item.
   assign advance    = in_valid_ff && (count_ff <= AdvanceLimit);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   assign cov_clamped = (req_tdata[7:0] > FULL_COVER) ? FULL_COVER : req_tdata[7:0];

   // Run encoding of the item held in the input register. The state only moves on in
   // the cycle in which the item's bytes go into the queue.
   always_comb begin
      pending_in     = pending_ff;
      held_in        = held_ff;
      run_count_in   = run_count_ff;
      chunk_in       = chunk_ff;
      pixel_total_in = pixel_total_ff;
      line_origin_in = line_origin_ff;
      slot_count     = '0;
      for (int i = 0; i < ITEM_BYTES_MAX; i++) begin
         slot[i] = '0;
      end

      // A zero count means this item opens a new line.
      origin     = (pixel_total_ff == '0) ? in_sx_ff : line_origin_ff;
      total_step = (pixel_total_ff != LengthCeiling) ? pixel_total_ff + 1'b1 : pixel_total_ff;

      if (advance) begin
         line_origin_in = origin;
         pixel_total_in = total_step;

         if (pending_in && (in_cov_ff == held_in)) begin
            run_count_in = run_count_in + 1'b1;
            // A full chunk leaves at once; the run stays open.
            if (run_count_in == RunW'(MAX_RUN)) begin
               slot[slot_count].code_byte = MARKER_BASE + 8'(run_count_in);
               slot_count = slot_count + 1'b1;
               slot[slot_count].code_byte = held_in;
               slot_count = slot_count + 1'b1;
               run_count_in = '0;
               chunk_in = 1'b1;
            end
         end else begin
            // Flush the run that this value breaks.
            if (pending_in && (run_count_in != '0)) begin
               if ((run_count_in == RunW'(1)) && !chunk_in) begin
                  slot[slot_count].code_byte = held_in;
                  slot_count = slot_count + 1'b1;
               end else begin
                  slot[slot_count].code_byte = MARKER_BASE + 8'(run_count_in);
                  slot_count = slot_count + 1'b1;
                  slot[slot_count].code_byte = held_in;
                  slot_count = slot_count + 1'b1;
               end
            end
            pending_in   = 1'b1;
            held_in      = in_cov_ff;
            run_count_in = RunW'(1);
            chunk_in     = 1'b0;
         end

         if (in_eol_ff) begin
            if (run_count_in != '0) begin
               if ((run_count_in == RunW'(1)) && !chunk_in) begin
                  slot[slot_count].code_byte = held_in;
                  slot_count = slot_count + 1'b1;
               end else begin
                  slot[slot_count].code_byte = MARKER_BASE + 8'(run_count_in);
                  slot_count = slot_count + 1'b1;
                  slot[slot_count].code_byte = held_in;
                  slot_count = slot_count + 1'b1;
               end
            end
            // The last byte of the line carries its start and length.
            if (slot_count != '0) begin
               slot[slot_count - 1'b1].final_byte  = 1'b1;
               slot[slot_count - 1'b1].line_start  = origin;
               slot[slot_count - 1'b1].line_length = 16'(total_step);
            end
            pending_in     = 1'b0;
            held_in        = '0;
            run_count_in   = '0;
            chunk_in       = 1'b0;
            pixel_total_in = '0;
         end
      end
   end

   assign push_count = advance ? slot_count : 2'd0;
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {head.line_length, head.line_start, head.code_byte};
   assign rsp_tlast  = head.final_byte;
   assign pop        = rsp_tvalid && rsp_tready;

   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff + (PtrW + 1)'(push_count) - (PtrW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         pending_ff     <= 1'b0;
         held_ff        <= '0;
         run_count_ff   <= '0;
         chunk_ff       <= 1'b0;
         pixel_total_ff <= '0;
         line_origin_ff <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         pending_ff     <= pending_in;
         held_ff        <= held_in;
         run_count_ff   <= run_count_in;
         chunk_ff       <= chunk_in;
         pixel_total_ff <= pixel_total_in;
         line_origin_ff <= line_origin_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cov_ff <= cov_clamped;
         in_sx_ff  <= req_tdata[23:8];
         in_eol_ff <= req_tlast;
      end
      for (int i = 0; i < ITEM_BYTES_MAX; i++) begin
         if (2'(i) < push_count) begin
            queue_ff[wr_ptr_ff + PtrW'(i)] <= slot[i];
         end
      end
   end

endmodule

### design/rle_coverage_encoder_checker.sv
// Port-level checker for the run-length coverage encoder, with its bind.
`include "rle_coverage_encoder_defines.svh"

module rle_coverage_encoder_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result item holds still.
   `RLE_ASSERT_NEXT(rsp_hold_a, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Start and length appear only on the final byte of a line.
   `RLE_ASSERT_IMPLY(rsp_side_zero_a, rsp_tvalid && !rsp_tlast, rsp_tdata[39:8] == 32'd0)

   // A line always holds at least one pixel.
   `RLE_ASSERT_IMPLY(rsp_length_a, rsp_tvalid && rsp_tlast, rsp_tdata[39:24] != 16'd0)

   // The final byte is a literal or a run value, never a marker.
   `RLE_ASSERT_IMPLY(rsp_final_value_a, rsp_tvalid && rsp_tlast, rsp_tdata[7:0] <= 8'd128)

   // Reset empties the result queue.
   `RLE_ASSERT_RESET(rsp_reset_a, reset, !rsp_tvalid)

endmodule

bind rle_coverage_encoder rle_coverage_encoder_checker u_rle_coverage_encoder_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### sim/testbench.sv
// Self-checking testbench for the run-length coverage encoder, with a byte scoreboard.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rlecov_pkg::*;

   // Cycles with no item moving on either side before the run is abandoned. Random gaps
   // are far shorter than the longest deliberate stall.
   localparam int STALL_LIMIT    = 4000;
   // Cycles to wait after the last expected item.
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_OFF       = 300;
   localparam int ITEMS_PER_MODE = 32;
   localparam int PRESSURE_ITEMS = 24;

   // Scoreboard: predicts the code bytes of every accepted pixel and checks each
   // result item against the oldest prediction.
   class rle_byte_scoreboard;
      rlecov_entry_type expected_q[$];
      rlecov_entry_type step_q[$];
      int               failures    = 0;
      bit               run_open    = 1'b0;
      logic [7:0]       run_value   = '0;
      logic [6:0]       run_len     = '0;
      bit               chunk_sent  = 1'b0;
      logic [15:0]      pixel_count = '0;
      logic [15:0]      origin_x    = '0;

      function void push_code(logic [7:0] code);
         rlecov_entry_type e;
         e = '0;
         e.code_byte = code;
         step_q.push_back(e);
      endfunction

      // A lone pixel that never completed a chunk leaves as a literal; anything else
      // leaves as a marker followed by the value.
      function void flush_open_run();
         if (!run_open || run_len == 0) return;
         if (run_len == 1 && !chunk_sent) begin
            push_code(run_value);
         end else begin
            push_code(MARKER_BASE + 8'(run_len));
            push_code(run_value);
         end
      endfunction

      function void absorb_pixel(logic [7:0] coverage, logic [15:0] start_x, bit end_of_line);
         logic [7:0] cov;
         int         last;
         step_q.delete();
         cov = (coverage > FULL_COVER) ? FULL_COVER : coverage;
         if (pixel_count == 0) origin_x = start_x;
         if (pixel_count != 16'hFFFF) pixel_count++;
         if (run_open && cov == run_value) begin
            run_len++;
            if (run_len >= MAX_RUN_DEFAULT) begin
               push_code(MARKER_BASE + 8'(run_len));
               push_code(run_value);
               run_len    = '0;
               chunk_sent = 1'b1;
            end
         end else begin
            flush_open_run();
            run_open   = 1'b1;
            run_value  = cov;
            run_len    = 7'd1;
            chunk_sent = 1'b0;
         end
         if (end_of_line) begin
            flush_open_run();
            if (step_q.size() > 0) begin
               last = step_q.size() - 1;
               step_q[last].final_byte  = 1'b1;
               step_q[last].line_start  = origin_x;
               step_q[last].line_length = pixel_count;
            end
            run_open    = 1'b0;
            run_value   = '0;
            run_len     = '0;
            chunk_sent  = 1'b0;
            pixel_count = '0;
         end
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      function void compare_byte(logic [39:0] data, logic last);
         rlecov_entry_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: code byte %h arrived with none expected", $time, data[7:0]);
            failures++;
            return;
         end
         e = expected_q.pop_front();
         if (data[7:0] !== e.code_byte) begin
            $display("%0t: code_byte expected %h actual %h", $time, e.code_byte, data[7:0]);
            failures++;
         end
         if (last !== e.final_byte) begin
            $display("%0t: final_byte expected %b actual %b", $time, e.final_byte, last);
            failures++;
         end
         if (data[23:8] !== e.line_start) begin
            $display("%0t: line_start expected %h actual %h", $time, e.line_start,
                     data[23:8]);
            failures++;
         end
         if (data[39:24] !== e.line_length) begin
            $display("%0t: line_length expected %h actual %h", $time, e.line_length,
                     data[39:24]);
            failures++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] coverage, [23:8] start_x
   logic        req_tlast  = 1'b0; // end_of_line
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [7:0] code_byte, [23:8] line_start, [39:24] line_length
   logic        rsp_tlast;         // final_byte

   rle_byte_scoreboard sb = new();

   // Idling controls, changed by the stimulus between modes.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_pending  = 0;
   int hold_left     = 0;
   int pixels_sent   = 0;
   int quiet_cycles  = 0;

   rle_coverage_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver side. A hold-off requested by the stimulus is counted here, so the sender
   // keeps offering items while the result queue fills and the input backs up.
   always @(posedge clock) begin
      if (hold_pending != 0) begin
         hold_left    = hold_pending;
         hold_pending = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Every result item that leaves the block is checked as it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.compare_byte(rsp_tdata, rsp_tlast);
   end

   // Watchdog: counts cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("testbench failed");
            $finish;
         end
      end
   end

   // Offers one pixel, with random idle cycles before it, and waits until it is taken.
   // The valid is left high afterwards so that back-to-back items stay back to back.
   task automatic offer_pixel(input logic [7:0] coverage, input logic [15:0] start_x,
                              input bit eol);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {start_x, coverage};
      req_tlast  <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.absorb_pixel(coverage, start_x, eol);
      pixels_sent++;
   endtask

   // A stretch of equal pixels; only the final one may close the line.
   task automatic offer_run(input logic [7:0] coverage, input int count, input bit eol);
      for (int i = 1; i <= count; i++)
         offer_pixel(coverage, 16'($urandom_range(0, 65535)), eol && (i == count));
   endtask

   // One random scanline built from a few runs. Values come mostly from a small palette
   // so that neighbouring runs sometimes merge; now and then a value above full cover
   // or a run around the chunk size is chosen.
   task automatic offer_random_line();
      int         runs;
      int         count;
      int         pick;
      logic [7:0] value;
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs; r++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) value = 8'($urandom_range(0, 255));
         else if (pick < 20) value = FULL_COVER;
         else value = 8'($urandom_range(0, 4) * 32);
         pick = $urandom_range(0, 99);
         if (pick < 70) count = $urandom_range(1, 4);
         else if (pick < 94) count = $urandom_range(5, 20);
         else count = $urandom_range(MAX_RUN_DEFAULT - 1, MAX_RUN_DEFAULT + 2);
         offer_run(value, count, r == runs - 1);
      end
   endtask

   initial begin
      int mode_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines, sent without idling. Single-pixel lines at the extremes of both
      // fields, with a coverage above full cover that must be clamped.
      offer_pixel(8'd0, 16'h0000, 1'b1);
      offer_pixel(8'd255, 16'hFFFF, 1'b1);
      // 128 and 129 count as one run of two once clamped, followed by a literal.
      offer_pixel(8'd128, 16'h5A5A, 1'b0);
      offer_pixel(8'd129, 16'hA5A5, 1'b0);
      offer_pixel(8'd5, 16'h0000, 1'b1);
      // A plain run of three, then a line of literals.
      offer_run(8'd7, 3, 1'b1);
      offer_pixel(8'd1, 16'h8001, 1'b0);
      offer_pixel(8'd2, 16'h7FFE, 1'b0);
      offer_pixel(8'd3, 16'h1234, 1'b1);
      // One pixel past a full chunk: the remainder still carries a marker.
      offer_run(8'd96, MAX_RUN_DEFAULT + 1, 1'b1);

      // The receiver holds off for a long stretch while a line of alternating values
      // keeps arriving. Each new value flushes the one before it as a literal, so the queue
      // fills and the input stalls.
      hold_pending = HOLD_OFF;
      for (int i = 0; i < PRESSURE_ITEMS; i++)
         offer_pixel((i % 2 == 0) ? 8'd16 : 8'd48, 16'h2222, i == PRESSURE_ITEMS - 1);

      // Random lines under each idling mode.
      for (int m = 0; m < 4; m++) begin
         case (m)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 64;
            end
            default: begin
               send_idle_pct = 20;
               stall_pct     = 20;
            end
         endcase
         mode_start = pixels_sent;
         while (pixels_sent - mode_start < ITEMS_PER_MODE) offer_random_line();
      end
      req_tvalid <= 1'b0;

      // Drain: the watchdog catches results that never come.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.expected_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
